[sv/dpfr_pkg.sv]
package dpfr_pkg;

  // Default geometry
  localparam int DEF_PAGE_BYTES   = 4096;
  localparam int DEF_MAX_SEGMENTS = 16;
  localparam int DEF_MAX_PAGES    = 64;

  // Per-segment page counter width
  localparam int PCNT_W = 21;

  // Item kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_FAULT   = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_MAPPED  = 3'd0;
  localparam logic [2:0] ST_DOUBLE  = 3'd1;
  localparam logic [2:0] ST_NOSEG   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_WRITTEN = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [3:0]  segment_index;
    logic [31:0] segment_start;
    logic [31:0] segment_mem_size;
    logic [31:0] segment_file_offset;
    logic [31:0] segment_file_size;
    logic [31:0] fault_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] page_address;
    logic [31:0] file_position;
    logic [12:0] load_bytes;
    logic [3:0]  segment_hit;
    logic        segment_complete;
    logic [31:0] fault_total;
    logic [31:0] fragmentation_total;
  } rsp_t;

  // One segment table row
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] mem_size;
    logic [31:0] file_offset;
    logic [31:0] file_size;
  } seg_entry_t;

  // Sequencer to page store
  typedef struct packed {
    logic scan;
    logic append;
  } pst_ctl_t;

  // Page store to sequencer
  typedef struct packed {
    logic done;
    logic dup;
    logic full;
  } pst_sts_t;

  function automatic rsp_t mk_rsp(input logic [2:0] status, input logic [31:0] page,
                                  input logic [31:0] fpos, input logic [12:0] lbytes,
                                  input logic [3:0] hit, input logic comp,
                                  input logic [31:0] ftot, input logic [31:0] frag);
    rsp_t r;
    r.status              = status;
    r.page_address        = page;
    r.file_position       = fpos;
    r.load_bytes          = lbytes;
    r.segment_hit         = hit;
    r.segment_complete    = comp;
    r.fault_total         = ftot;
    r.fragmentation_total = frag;
    return r;
  endfunction

endpackage

[sv/dpfr_ram.sv]
module dpfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/dpfr_pstore.sv]
module dpfr_pstore #(
  parameter int PAGE_W    = 20,
  parameter int MAX_PAGES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  dpfr_pkg::pst_ctl_t ctl,
  input  logic [PAGE_W-1:0]  page,
  output dpfr_pkg::pst_sts_t sts
);
  import dpfr_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic              scanning;
  logic              rd_vld;
  logic              dup;
  logic              issue;
  logic [PAGE_W-1:0] rdata;

  // Walk the filled entries, one read per cycle
  assign issue = scanning && (ptr < count);

  dpfr_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_ram (
    .clk   (clk),
    .we    (ctl.append),
    .waddr (count[IDX_W-1:0]),
    .wdata (page),
    .re    (issue),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    sts.done = scanning && !issue && !rd_vld;
    sts.dup  = dup;
    sts.full = (count == CNT_W'(MAX_PAGES));
  end

  // Scan control and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ptr      <= '0;
      scanning <= 1'b0;
      rd_vld   <= 1'b0;
      dup      <= 1'b0;
    end else begin
      if (ctl.scan) begin
        ptr      <= '0;
        scanning <= 1'b1;
        rd_vld   <= 1'b0;
        dup      <= 1'b0;
      end else if (scanning) begin
        rd_vld <= issue;
        if (issue) begin
          ptr <= ptr + 1'b1;
        end
        if (rd_vld && (rdata == page)) begin
          dup <= 1'b1;
        end
        if (sts.done) begin
          scanning <= 1'b0;
        end
      end
      if (ctl.append) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

[sv/demand_page_fault_resolver_core.sv]
// Channel  Direction  Handshake                  Beat
// req      in         req_valid / req_stall      req_t: segment write or page fault
// rsp      out        rsp_valid / rsp_stall      rsp_t: one result per req beat
// cfg      in         cfg_valid / cfg_ready      segment_count, 5 bits
//
// Segment write: accept goes straight to S_EMIT. Page fault: the page store is walked, then, unless
// the page is a duplicate, the segments searched; a mapped fault then passes S_OFFS, S_CALC
// and S_UPD before S_EMIT; each walk reads one RAM entry a cycle.
// Reset clears the counters, the fill count and the page-count valid bits; no sweep.
// rsp_stall holds the output register; one more req beat is taken meanwhile and its
// result waits in the sequencer until the register frees.
module demand_page_fault_resolver_core #(
  parameter int PAGE_BYTES   = dpfr_pkg::DEF_PAGE_BYTES,
  parameter int MAX_SEGMENTS = dpfr_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_PAGES    = dpfr_pkg::DEF_MAX_PAGES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dpfr_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dpfr_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [4:0]     cfg_data
);
  import dpfr_pkg::*;

  localparam int SHIFT  = $clog2(PAGE_BYTES);
  localparam int PAGE_W = 32 - SHIFT;
  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SCNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int TP_W   = 33 - SHIFT;
  localparam int CMP_W  = (TP_W > PCNT_W) ? TP_W : PCNT_W;
  localparam logic [SHIFT:0] PAGE_V = (SHIFT + 1)'(PAGE_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PSCAN = 3'd1;
  localparam logic [2:0] S_SSCAN = 3'd2;
  localparam logic [2:0] S_OFFS  = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]        state;
  logic              req_acc;
  logic [4:0]        seg_count;
  logic [31:0]       fault_addr;
  logic [31:0]       page_addr;
  pst_ctl_t          pst_ctl;
  pst_sts_t          pst_sts;
  logic              idx_ok;
  logic              seg_we;
  logic              seg_re;
  seg_entry_t        seg_wr;
  seg_entry_t        seg_rd;
  logic [32:0]       seg_end;
  logic              seg_match;
  logic [SCNT_W-1:0] sptr;
  logic [SCNT_W-1:0] slimit;
  logic [SCNT_W-1:0] slimit_next;
  logic              srd_vld;
  logic [SEG_W-1:0]  sidx;
  logic [SEG_W-1:0]  hit_idx;
  seg_entry_t        ent;
  logic              cnt_re;
  logic              cnt_we;
  logic [PCNT_W-1:0] cnt_rd;
  logic [MAX_SEGMENTS-1:0] cnt_vld;
  logic [PCNT_W-1:0] cnt_cur;
  logic [PCNT_W-1:0] cnt_new;
  logic [31:0]       offset;
  logic [31:0]       left;
  logic [31:0]       bytes;
  logic [31:0]       pos_in_file;
  logic [12:0]       load_b;
  logic [TP_W-1:0]   tp;
  logic              complete;
  logic [SHIFT-1:0]  tail_used;
  logic [SHIFT:0]    waste;
  logic [32:0]       waste_sum;
  logic [31:0]       faults;
  logic [31:0]       faults_next;
  logic [31:0]       wasted;
  logic [31:0]       wasted_next;
  logic [31:0]       hit_ext;
  rsp_t              res;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign page_addr = {fault_addr[31:SHIFT], {SHIFT{1'b0}}};

  // Segment table write on accept, read during the search
  always_comb begin
    idx_ok             = ({28'd0, req.segment_index} < 32'(MAX_SEGMENTS));
    seg_we             = req_acc && (req.kind == KIND_SEGMENT) && idx_ok;
    seg_wr.start       = req.segment_start;
    seg_wr.mem_size    = req.segment_mem_size;
    seg_wr.file_offset = req.segment_file_offset;
    seg_wr.file_size   = req.segment_file_size;
    seg_re             = (state == S_SSCAN) && (sptr < slimit);
    seg_end            = {1'b0, seg_rd.start} + {1'b0, seg_rd.mem_size};
    seg_match          = srd_vld && (fault_addr >= seg_rd.start) &&
                         ({1'b0, fault_addr} < seg_end);
    cnt_re             = (state == S_SSCAN) && seg_match;
    cnt_we             = (state == S_UPD);
    pst_ctl.scan       = req_acc && (req.kind == KIND_FAULT);
    pst_ctl.append     = (state == S_UPD);
    if ({27'd0, seg_count} > 32'(MAX_SEGMENTS)) begin
      slimit_next = SCNT_W'(MAX_SEGMENTS);
    end else begin
      slimit_next = SCNT_W'(seg_count);
    end
  end

  dpfr_ram #(.WIDTH($bits(seg_entry_t)), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (SEG_W'(req.segment_index)),
    .wdata (seg_wr),
    .re    (seg_re),
    .raddr (sptr[SEG_W-1:0]),
    .rdata (seg_rd)
  );

  dpfr_ram #(.WIDTH(PCNT_W), .DEPTH(MAX_SEGMENTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (hit_idx),
    .wdata (cnt_new),
    .re    (cnt_re),
    .raddr (sidx),
    .rdata (cnt_rd)
  );

  dpfr_pstore #(.PAGE_W(PAGE_W), .MAX_PAGES(MAX_PAGES)) u_pstore (
    .clk  (clk),
    .rst  (rst),
    .ctl  (pst_ctl),
    .page (fault_addr[31:SHIFT]),
    .sts  (pst_sts)
  );

  // File bytes left from the page start, capped at one page
  always_comb begin
    left  = (ent.file_size > offset) ? (ent.file_size - offset) : 32'd0;
    bytes = (left < 32'(PAGE_BYTES)) ? left : 32'(PAGE_BYTES);
  end

  // Final-page check, tail waste, saturating totals
  always_comb begin
    tp          = TP_W'(ent.mem_size >> SHIFT) + TP_W'(|ent.mem_size[SHIFT-1:0]);
    complete    = (CMP_W'(cnt_new) == CMP_W'(tp));
    tail_used   = ent.mem_size[SHIFT-1:0];
    waste       = PAGE_V - {1'b0, tail_used};
    waste_sum   = {1'b0, wasted} + 33'(waste);
    faults_next = (faults == 32'hFFFF_FFFF) ? faults : faults + 32'd1;
    wasted_next = wasted;
    if (complete && (tail_used != '0)) begin
      wasted_next = waste_sum[32] ? 32'hFFFF_FFFF : waste_sum[31:0];
    end
    hit_ext     = 32'(hit_idx);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      seg_count <= '0;
      faults    <= '0;
      wasted    <= '0;
      cnt_vld   <= '0;
      srd_vld   <= 1'b0;
      sptr      <= '0;
      slimit    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seg_count <= cfg_data;
      end
      // the emit state reloads the output register itself
      if (rsp_valid && !rsp_stall && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (req.kind == KIND_FAULT) begin
              fault_addr <= req.fault_address;
              state      <= S_PSCAN;
            end else begin
              res   <= mk_rsp(ST_WRITTEN, '0, '0, '0, '0, 1'b0, faults, wasted);
              state <= S_EMIT;
            end
          end
        end
        S_PSCAN: begin
          if (pst_sts.done) begin
            if (pst_sts.dup) begin
              res   <= mk_rsp(ST_DOUBLE, page_addr, '0, '0, '0, 1'b0, faults, wasted);
              state <= S_EMIT;
            end else begin
              sptr    <= '0;
              srd_vld <= 1'b0;
              slimit  <= slimit_next;
              state   <= S_SSCAN;
            end
          end
        end
        S_SSCAN: begin
          srd_vld <= seg_re;
          sidx    <= sptr[SEG_W-1:0];
          if (seg_re) begin
            sptr <= sptr + 1'b1;
          end
          if (seg_match) begin
            if (pst_sts.full) begin
              res   <= mk_rsp(ST_FULL, page_addr, '0, '0, '0, 1'b0, faults, wasted);
              state <= S_EMIT;
            end else begin
              hit_idx <= sidx;
              ent     <= seg_rd;
              state   <= S_OFFS;
            end
          end else if (!srd_vld && !seg_re) begin
            res   <= mk_rsp(ST_NOSEG, page_addr, '0, '0, '0, 1'b0, faults, wasted);
            state <= S_EMIT;
          end
        end
        S_OFFS: begin
          offset  <= page_addr - ent.start;
          cnt_cur <= cnt_vld[hit_idx] ? cnt_rd : '0;
          state   <= S_CALC;
        end
        S_CALC: begin
          pos_in_file <= ent.file_offset + offset;
          load_b      <= bytes[12:0];
          cnt_new     <= (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;
          state       <= S_UPD;
        end
        S_UPD: begin
          faults           <= faults_next;
          wasted           <= wasted_next;
          cnt_vld[hit_idx] <= 1'b1;
          res   <= mk_rsp(ST_MAPPED, page_addr, pos_in_file, load_b, hit_ext[3:0], complete,
                          faults_next, wasted_next);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted beat always starts work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> (state != S_IDLE))
    else $error("sequencer idle after accepting a beat");

  // A page is only recorded when the store has room
  a_no_append_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> !pst_sts.full)
    else $error("page store append while full");

  // The segment walk never runs past the searched range
  a_sptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SSCAN) |-> (sptr <= slimit))
    else $error("segment walk past limit");

  // A mapped page bumps the fault total unless saturated
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> ((faults != $past(faults)) || ($past(faults) == 32'hFFFF_FFFF)))
    else $error("fault total not advanced");
`endif

endmodule
